>>> hw/rtl/wrs_pkg.sv
// Shared sizes and operation/status codes for the weighted random selector.
// No dependencies; used by weighted_random_selector_core.
package wrs_pkg;

   localparam int ENTRIES         = 64;
   localparam int WEIGHT_BITS     = 16;
   localparam int IDX_BITS        = $clog2(ENTRIES);
   localparam int COUNT_BITS      = $clog2(ENTRIES + 1);
   localparam int TOTAL_BITS      = WEIGHT_BITS + IDX_BITS;
   localparam int FRAC_BITS       = 16;
   localparam int REQ_WEIGHT_BITS = 16;
   localparam int MODE_BITS       = 2;
   localparam int OUT_IDX_BITS    = 6;
   localparam int STATUS_BITS     = 2;

   localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_SELECT = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd3;

endpackage

>>> hw/rtl/weighted_random_selector_core.sv
// Weighted random selector: add/clear/select over a table of entry weights.
// Add, clear, errors and the unused mode answer from idle: result valid the cycle after accept.
// Select: a scale step multiplies the fraction by the total (one multiplier), then one stored weight
//   per cycle through a single subtract/compare unit and one memory read port, then a done state
//   that issues the result once the output slot is free; one item in flight at a time.
// Synchronous active-high reset clears count, total and handshake state; the weight memory is
//   not cleared, only entries below the fill count are used. Depends on wrs_pkg.
module weighted_random_selector_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [wrs_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [wrs_pkg::REQ_WEIGHT_BITS-1:0] req_weight,
   input  logic [wrs_pkg::FRAC_BITS-1:0]       req_random_fraction,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wrs_pkg::OUT_IDX_BITS-1:0]    rsp_entry_index,
   output logic [wrs_pkg::STATUS_BITS-1:0]     rsp_status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_WALK,
      ST_DONE
   } state_type;

   localparam int PROD_BITS = wrs_pkg::FRAC_BITS + wrs_pkg::TOTAL_BITS;

   state_type                            state_ff, state_in;
   logic [wrs_pkg::COUNT_BITS-1:0]       count_ff, count_in;
   logic [wrs_pkg::TOTAL_BITS-1:0]       total_ff, total_in;
   logic [wrs_pkg::FRAC_BITS-1:0]        frac_ff, frac_in;
   logic [wrs_pkg::TOTAL_BITS-1:0]       rem_ff, rem_in;
   logic [wrs_pkg::IDX_BITS-1:0]         idx_ff, idx_in;
   logic [wrs_pkg::IDX_BITS-1:0]         pick_ff, pick_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [wrs_pkg::OUT_IDX_BITS-1:0]     rsp_index_ff, rsp_index_in;
   logic [wrs_pkg::STATUS_BITS-1:0]      rsp_status_ff, rsp_status_in;

   logic [wrs_pkg::WEIGHT_BITS-1:0]      weight_mem [wrs_pkg::ENTRIES];
   logic [wrs_pkg::WEIGHT_BITS-1:0]      rd_data_ff;
   logic [wrs_pkg::IDX_BITS-1:0]         rd_addr;
   logic                                 wr_en;

   logic                                 out_free;
   logic                                 accept;
   logic [wrs_pkg::WEIGHT_BITS-1:0]      weight_masked;
   logic [PROD_BITS-1:0]                 product;
   logic [wrs_pkg::TOTAL_BITS-1:0]       weight_ext;
   logic                                 idx_last;
   logic                                 table_full;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == ST_IDLE) && out_free;
   assign accept        = req_valid && req_ready;
   assign weight_masked = wrs_pkg::WEIGHT_BITS'(req_weight);
   assign product       = PROD_BITS'(frac_ff) * PROD_BITS'(total_ff);
   assign weight_ext    = wrs_pkg::TOTAL_BITS'(rd_data_ff);
   assign idx_last      = (wrs_pkg::COUNT_BITS'(idx_ff) + wrs_pkg::COUNT_BITS'(1)) == count_ff;
   assign table_full    = count_ff == wrs_pkg::COUNT_BITS'(wrs_pkg::ENTRIES);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      frac_in       = frac_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      pick_in       = pick_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      rd_addr       = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_status_in = wrs_pkg::STATUS_OK;
               case (req_mode)
                  wrs_pkg::MODE_ADD: begin
                     if (weight_masked == '0) begin
                        rsp_status_in = wrs_pkg::STATUS_ZERO;
                     end else if (table_full) begin
                        rsp_status_in = wrs_pkg::STATUS_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        rsp_index_in = wrs_pkg::OUT_IDX_BITS'(count_ff[wrs_pkg::IDX_BITS-1:0]);
                        count_in     = count_ff + wrs_pkg::COUNT_BITS'(1);
                        total_in     = total_ff + wrs_pkg::TOTAL_BITS'(weight_masked);
                     end
                  end
                  wrs_pkg::MODE_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  wrs_pkg::MODE_SELECT: begin
                     if (count_ff == '0) begin
                        rsp_status_in = wrs_pkg::STATUS_EMPTY;
                     end else begin
                        // hold the result slot until the walk finishes
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        frac_in      = req_random_fraction;
                        state_in     = ST_SCALE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCALE: begin
            // target in whole weight units; the fraction bits never change the compares
            rem_in   = product[PROD_BITS-1:wrs_pkg::FRAC_BITS];
            idx_in   = '0;
            rd_addr  = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            rd_addr = idx_ff + wrs_pkg::IDX_BITS'(1);
            if (rem_ff < weight_ext) begin
               pick_in  = idx_ff;
               state_in = ST_DONE;
            end else begin
               rem_in = rem_ff - weight_ext;
               if (idx_last) begin
                  pick_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + wrs_pkg::IDX_BITS'(1);
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = wrs_pkg::OUT_IDX_BITS'(pick_ff);
               rsp_status_in = wrs_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frac_ff       <= frac_in;
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      pick_ff       <= pick_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem[count_ff[wrs_pkg::IDX_BITS-1:0]] <= weight_masked;
      end
      rd_data_ff <= weight_mem[rd_addr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wrs_pkg::COUNT_BITS'(wrs_pkg::ENTRIES))
      else $error("entry count above table size");

   a_total_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (total_ff == '0))
      else $error("total weight out of step with entry count");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (wrs_pkg::COUNT_BITS'(idx_ff) < count_ff))
      else $error("walk index past last entry");

   a_error_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != wrs_pkg::STATUS_OK) |-> (rsp_index_ff == '0))
      else $error("nonzero index with error status");

endmodule

>>> dv/tb.sv
// Self-checking bench for weighted_random_selector_core: drives add, clear and select items
// and checks every result against an in-bench model of the weight table and running total.
// Depends on wrs_pkg and weighted_random_selector_core.
`timescale 1ns / 100ps

module tb;

   localparam logic [wrs_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam int ITEM_TARGET  = 1500;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PRESSURE_AT  = 50;
   localparam int PRESSURE_LEN = 400;

   typedef enum int {
      PHASE_STEADY,
      PHASE_SENDER_IDLE,
      PHASE_RECEIVER_STALL,
      PHASE_BOTH_IDLE
   } idling_phase_type;

   typedef struct packed {
      logic [wrs_pkg::MODE_BITS-1:0]       mode;
      logic [wrs_pkg::REQ_WEIGHT_BITS-1:0] weight;
      logic [wrs_pkg::FRAC_BITS-1:0]       fraction;
   } wrs_item_type;

   typedef struct packed {
      logic [wrs_pkg::OUT_IDX_BITS-1:0] entry_index;
      logic [wrs_pkg::STATUS_BITS-1:0]  status;
   } wrs_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [wrs_pkg::MODE_BITS-1:0]       req_mode = wrs_pkg::MODE_CLEAR;
   logic [wrs_pkg::REQ_WEIGHT_BITS-1:0] req_weight = '0;
   logic [wrs_pkg::FRAC_BITS-1:0]       req_random_fraction = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [wrs_pkg::OUT_IDX_BITS-1:0]    rsp_entry_index;
   logic [wrs_pkg::STATUS_BITS-1:0]     rsp_status;

   // Model state
   logic [wrs_pkg::WEIGHT_BITS-1:0] weight_store [wrs_pkg::ENTRIES];
   logic [wrs_pkg::COUNT_BITS-1:0]  fill_count = '0;
   logic [wrs_pkg::TOTAL_BITS-1:0]  weight_sum = '0;

   wrs_item_type   pending_items [$];
   wrs_result_type expected_results [$];
   wrs_item_type   offered_item;
   int             total_planned = 0;
   int             items_accepted = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   int             hold_left = 0;
   bit             pressure_done = 1'b0;

   weighted_random_selector_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_weight          (req_weight),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_status          (rsp_status)
   );

   always #4 clock = ~clock;

   function automatic idling_phase_type current_phase();
      return idling_phase_type'((items_accepted * 4) / (total_planned + 1));
   endfunction

   // Apply one item to the model state and return the result it must produce.
   function automatic wrs_result_type apply_to_table(input wrs_item_type item);
      wrs_result_type                  res;
      logic [wrs_pkg::WEIGHT_BITS-1:0] w;
      logic [63:0]                     remain;
      logic [63:0]                     scaled_weight;
      int                              pick;
      bit                              found;
      res.entry_index = '0;
      res.status      = wrs_pkg::STATUS_OK;
      w = wrs_pkg::WEIGHT_BITS'(item.weight);
      case (item.mode)
         wrs_pkg::MODE_ADD: begin
            if (w == '0) begin
               res.status = wrs_pkg::STATUS_ZERO;
            end else if (int'(fill_count) >= wrs_pkg::ENTRIES) begin
               res.status = wrs_pkg::STATUS_FULL;
            end else begin
               weight_store[fill_count] = w;
               weight_sum = weight_sum + wrs_pkg::TOTAL_BITS'(w);
               res.entry_index = wrs_pkg::OUT_IDX_BITS'(fill_count);
               fill_count = fill_count + wrs_pkg::COUNT_BITS'(1);
            end
         end
         wrs_pkg::MODE_CLEAR: begin
            fill_count = '0;
            weight_sum = '0;
         end
         wrs_pkg::MODE_SELECT: begin
            if (fill_count == '0) begin
               res.status = wrs_pkg::STATUS_EMPTY;
            end else begin
               // Target in Q.16: fraction times total, walked down by weight << 16.
               remain = 64'(item.fraction) * 64'(weight_sum);
               pick = 0;
               found = 1'b0;
               for (int i = 0; i < wrs_pkg::ENTRIES; i++) begin
                  if (!found && i < int'(fill_count)) begin
                     scaled_weight = 64'(weight_store[i]) << 16;
                     if (remain < scaled_weight) begin
                        pick = i;
                        found = 1'b1;
                     end else begin
                        remain = remain - scaled_weight;
                     end
                  end
               end
               res.entry_index = wrs_pkg::OUT_IDX_BITS'(pick);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [wrs_pkg::REQ_WEIGHT_BITS-1:0] pick_weight();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         2, 3:    return wrs_pkg::REQ_WEIGHT_BITS'($urandom_range(1, 15));
         default: return wrs_pkg::REQ_WEIGHT_BITS'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [wrs_pkg::FRAC_BITS-1:0] pick_fraction();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return wrs_pkg::FRAC_BITS'($urandom());
      endcase
   endfunction

   task automatic push_item(input logic [wrs_pkg::MODE_BITS-1:0] mode,
                            input logic [wrs_pkg::REQ_WEIGHT_BITS-1:0] weight,
                            input logic [wrs_pkg::FRAC_BITS-1:0] fraction);
      wrs_item_type item;
      item.mode     = mode;
      item.weight   = weight;
      item.fraction = fraction;
      pending_items = {pending_items, item};
   endtask

   // Request side: present items from the pending queue, idling per phase.
   always @(posedge clock) begin : drive_requests
      idling_phase_type phase;
      bit               sender_idles;
      phase = current_phase();
      sender_idles = (phase == PHASE_SENDER_IDLE && $urandom_range(0, 99) < 81) ||
                     (phase == PHASE_BOTH_IDLE && $urandom_range(0, 99) < 19);
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results = {expected_results, apply_to_table(offered_item)};
            items_accepted <= items_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && !sender_idles) begin
               offered_item = pending_items.pop_front();
               req_mode            <= offered_item.mode;
               req_weight          <= offered_item.weight;
               req_random_fraction <= offered_item.fraction;
               req_valid           <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: ready per phase, with one long hold-off early in the steady phase.
   always @(posedge clock) begin : drive_ready
      idling_phase_type phase;
      phase = current_phase();
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!pressure_done && items_accepted >= PRESSURE_AT) begin
         pressure_done <= 1'b1;
         hold_left <= PRESSURE_LEN;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (phase == PHASE_RECEIVER_STALL) begin
         rsp_ready <= $urandom_range(0, 99) >= 81;
      end else if (phase == PHASE_BOTH_IDLE) begin
         rsp_ready <= $urandom_range(0, 99) >= 19;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      wrs_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: entry_index %0d, status %0d",
                   rsp_entry_index, rsp_status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_entry_index !== want.entry_index) begin
               $error("entry_index mismatch: expected %0d, actual %0d",
                      want.entry_index, rsp_entry_index);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : run_test
      int n_adds;

      // Empty table, zero weight, unused mode, weight and fraction extremes.
      push_item(wrs_pkg::MODE_SELECT, '0, '0);
      push_item(wrs_pkg::MODE_SELECT, '1, '1);
      push_item(wrs_pkg::MODE_ADD, '0, '1);
      push_item(MODE_UNUSED, '1, '1);
      push_item(wrs_pkg::MODE_ADD, 16'hFFFF, '0);
      push_item(wrs_pkg::MODE_ADD, 16'h0001, '0);
      push_item(wrs_pkg::MODE_ADD, 16'h8000, '0);
      push_item(wrs_pkg::MODE_SELECT, '0, 16'h0000);
      push_item(wrs_pkg::MODE_SELECT, '0, 16'hFFFF);
      push_item(wrs_pkg::MODE_SELECT, '0, 16'h8000);
      push_item(wrs_pkg::MODE_SELECT, '0, 16'h7FFF);
      push_item(wrs_pkg::MODE_SELECT, '0, 16'h0001);
      push_item(wrs_pkg::MODE_ADD, '0, '0);
      push_item(wrs_pkg::MODE_CLEAR, '1, '1);
      push_item(wrs_pkg::MODE_SELECT, '1, 16'h1234);
      push_item(wrs_pkg::MODE_ADD, 16'h0001, '0);
      push_item(wrs_pkg::MODE_SELECT, '0, 16'hFFFF);
      push_item(wrs_pkg::MODE_ADD, 16'h5555, '0);
      push_item(wrs_pkg::MODE_ADD, 16'hAAAA, '0);
      push_item(wrs_pkg::MODE_SELECT, '0, 16'hAAAA);
      push_item(wrs_pkg::MODE_SELECT, '0, 16'h5555);
      push_item(MODE_UNUSED, '0, '0);

      // Mostly fill-then-select sequences; some fill the table past full.
      while (pending_items.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 3) != 0)
               push_item(wrs_pkg::MODE_CLEAR, wrs_pkg::REQ_WEIGHT_BITS'($urandom()),
                         wrs_pkg::FRAC_BITS'($urandom()));
            n_adds = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                 : $urandom_range(1, 8);
            repeat (n_adds)
               push_item(wrs_pkg::MODE_ADD, pick_weight(), wrs_pkg::FRAC_BITS'($urandom()));
            repeat ($urandom_range(1, 8))
               push_item(wrs_pkg::MODE_SELECT, wrs_pkg::REQ_WEIGHT_BITS'($urandom()),
                         pick_fraction());
         end else begin
            repeat ($urandom_range(1, 4))
               push_item(wrs_pkg::MODE_BITS'($urandom_range(0, 3)), pick_weight(),
                         pick_fraction());
         end
      end
      total_planned = pending_items.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < total_planned || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
